>>> rtl/pgarea_pkg.sv
// Shared constants and types of the polygon area / right-angle block.
// No dependencies; every other file of the block imports this package.
package pgarea_pkg;

  localparam int unsigned COORD_W          = 16;   // width of a coordinate on the port
  localparam int unsigned SUM_BITS         = 43;   // shoelace accumulator, wraps
  localparam int unsigned AREA_BITS        = 42;
  localparam int unsigned TOTAL_BITS       = 11;
  localparam int unsigned MIN_VERTICES     = 3;
  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF   = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_FEW  = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_e;

  // Per-vertex control that travels alongside the products.
  typedef struct packed {
    logic                  last;
    logic                  ok;        // last vertex of a valid polygon: add closing terms
    logic                  do_cross;  // cross term with the previous vertex counts
    logic                  do_dot0;   // angle at the previous vertex is tested
    logic [TOTAL_BITS-1:0] total;
    status_e               status;
  } ctl_t;

  // One finished polygon, before the magnitude is taken.
  typedef struct packed {
    logic [SUM_BITS-1:0]   sum;
    logic                  right;
    logic [TOTAL_BITS-1:0] total;
    status_e               status;
  } res_t;

endpackage

>>> rtl/pgarea_vtx_if.sv
// Vertex channel: valid/ready handshake with one polygon vertex per beat.
// Depends on pgarea_pkg.
interface pgarea_vtx_if;
  import pgarea_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic               last_vertex;

  modport source (output valid, output x_coord, output y_coord, output last_vertex,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input last_vertex,
                  output ready);
endinterface

>>> rtl/pgarea_res_if.sv
// Result channel: valid/ready handshake with one polygon result per beat.
// Depends on pgarea_pkg.
interface pgarea_res_if;
  import pgarea_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [AREA_BITS-1:0]  twice_area;
  logic                  right_angle_found;
  logic [TOTAL_BITS-1:0] vertex_total;
  logic [1:0]            status;

  modport source (output valid, output twice_area, output right_angle_found,
                  output vertex_total, output status, input ready);
  modport sink   (input valid, input twice_area, input right_angle_found,
                  input vertex_total, input status, output ready);
endinterface

>>> rtl/pgarea_front.sv
// Front stage: vertex history, vertex count and the registered edge products.
// Depends on pgarea_pkg and pgarea_vtx_if.
module pgarea_front #(
  parameter int unsigned MAX_VERTICES = pgarea_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pgarea_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pgarea_vtx_if.sink                      vtx_i,
  output logic                            s1_valid_o,
  input  logic                            s1_ready_i,
  output pgarea_pkg::ctl_t                s1_ctl_o,
  output logic signed [2*COORD_BITS-1:0]  cr_a_o,
  output logic signed [2*COORD_BITS-1:0]  cr_b_o,
  output logic signed [2*COORD_BITS-1:0]  cl_a_o,
  output logic signed [2*COORD_BITS-1:0]  cl_b_o,
  output logic signed [2*COORD_BITS+1:0]  d0_a_o,
  output logic signed [2*COORD_BITS+1:0]  d0_b_o,
  output logic signed [2*COORD_BITS+1:0]  d1_a_o,
  output logic signed [2*COORD_BITS+1:0]  d1_b_o,
  output logic signed [2*COORD_BITS+1:0]  d2_a_o,
  output logic signed [2*COORD_BITS+1:0]  d2_b_o
);
  import pgarea_pkg::*;

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned EW    = CW + 1;
  localparam int unsigned CPW   = 2 * CW;
  localparam int unsigned PW    = 2 * CW + 2;
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 2);

  logic signed [CW-1:0] px, py;
  logic signed [CW-1:0] fx_q, fy_q, sx_q, sy_q, ox_q, oy_q, rx_q, ry_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d, cnt_nxt;
  logic                 in_range, accept;
  logic                 s1_valid_q, s1_valid_d;
  ctl_t                 ctl_d, ctl_q;

  // Edges: older->recent, recent->new, new->first, first->second
  logic signed [EW-1:0] e_or_x, e_or_y, e_rp_x, e_rp_y, e_pf_x, e_pf_y, e_fs_x, e_fs_y;
  logic signed [CPW-1:0] cr_a_q, cr_b_q, cl_a_q, cl_b_q;
  logic signed [PW-1:0]  d0_a_q, d0_b_q, d1_a_q, d1_b_q, d2_a_q, d2_b_q;

  // Low COORD_BITS bits sign-extended; a wider setting sees the port value as positive
  if (CW <= COORD_W) begin : g_narrow
    assign px = vtx_i.x_coord[CW-1:0];
    assign py = vtx_i.y_coord[CW-1:0];
  end else begin : g_wide
    assign px = {{(CW-COORD_W){1'b0}}, vtx_i.x_coord};
    assign py = {{(CW-COORD_W){1'b0}}, vtx_i.y_coord};
  end

  assign vtx_i.ready = !s1_valid_q || s1_ready_i;
  assign accept      = vtx_i.valid && vtx_i.ready;

  assign in_range = cnt_q < CNT_W'(MAX_VERTICES);
  assign cnt_nxt  = in_range ? cnt_q + 1'b1 : CNT_W'(MAX_VERTICES + 1);

  always_comb begin
    ctl_d          = '0;
    ctl_d.last     = vtx_i.last_vertex;
    ctl_d.do_cross = in_range && (cnt_q >= CNT_W'(1));
    ctl_d.do_dot0  = in_range && (cnt_q >= CNT_W'(2));
    if (!in_range) begin
      ctl_d.status = ST_TOO_MANY;
      ctl_d.total  = TOTAL_BITS'(MAX_VERTICES);
    end else if (cnt_nxt < CNT_W'(MIN_VERTICES)) begin
      ctl_d.status = ST_TOO_FEW;
      ctl_d.total  = TOTAL_BITS'(cnt_nxt);
    end else begin
      ctl_d.status = ST_OK;
      ctl_d.total  = TOTAL_BITS'(cnt_nxt);
    end
    ctl_d.ok = vtx_i.last_vertex && (ctl_d.status == ST_OK);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = vtx_i.last_vertex ? '0 : cnt_nxt;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  assign e_or_x = EW'(rx_q) - EW'(ox_q);
  assign e_or_y = EW'(ry_q) - EW'(oy_q);
  assign e_rp_x = EW'(px)   - EW'(rx_q);
  assign e_rp_y = EW'(py)   - EW'(ry_q);
  assign e_pf_x = EW'(fx_q) - EW'(px);
  assign e_pf_y = EW'(fy_q) - EW'(py);
  assign e_fs_x = EW'(sx_q) - EW'(fx_q);
  assign e_fs_y = EW'(sy_q) - EW'(fy_q);

  // Payload: history and products, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (in_range) begin
        if (cnt_q == CNT_W'(0)) begin
          fx_q <= px;
          fy_q <= py;
        end
        if (cnt_q == CNT_W'(1)) begin
          sx_q <= px;
          sy_q <= py;
        end
        ox_q <= rx_q;
        oy_q <= ry_q;
        rx_q <= px;
        ry_q <= py;
      end
      ctl_q  <= ctl_d;
      cr_a_q <= CPW'(rx_q) * CPW'(py);
      cr_b_q <= CPW'(px)   * CPW'(ry_q);
      cl_a_q <= CPW'(px)   * CPW'(fy_q);
      cl_b_q <= CPW'(fx_q) * CPW'(py);
      d0_a_q <= PW'(e_or_x) * PW'(e_rp_x);
      d0_b_q <= PW'(e_or_y) * PW'(e_rp_y);
      d1_a_q <= PW'(e_rp_x) * PW'(e_pf_x);
      d1_b_q <= PW'(e_rp_y) * PW'(e_pf_y);
      d2_a_q <= PW'(e_pf_x) * PW'(e_fs_x);
      d2_b_q <= PW'(e_pf_y) * PW'(e_fs_y);
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_ctl_o   = ctl_q;
  assign cr_a_o     = cr_a_q;
  assign cr_b_o     = cr_b_q;
  assign cl_a_o     = cl_a_q;
  assign cl_b_o     = cl_b_q;
  assign d0_a_o     = d0_a_q;
  assign d0_b_o     = d0_b_q;
  assign d1_a_o     = d1_a_q;
  assign d1_b_o     = d1_b_q;
  assign d2_a_o     = d2_a_q;
  assign d2_b_o     = d2_b_q;

endmodule

>>> rtl/pgarea_accum.sv
// Term stage and accumulator: forms cross terms and right-angle tests, keeps the
// running shoelace sum and hands a finished polygon on. Depends on pgarea_pkg.
module pgarea_accum #(
  parameter int unsigned COORD_BITS = pgarea_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s1_valid_i,
  output logic                            s1_ready_o,
  input  pgarea_pkg::ctl_t                s1_ctl_i,
  input  logic signed [2*COORD_BITS-1:0]  cr_a_i,
  input  logic signed [2*COORD_BITS-1:0]  cr_b_i,
  input  logic signed [2*COORD_BITS-1:0]  cl_a_i,
  input  logic signed [2*COORD_BITS-1:0]  cl_b_i,
  input  logic signed [2*COORD_BITS+1:0]  d0_a_i,
  input  logic signed [2*COORD_BITS+1:0]  d0_b_i,
  input  logic signed [2*COORD_BITS+1:0]  d1_a_i,
  input  logic signed [2*COORD_BITS+1:0]  d1_b_i,
  input  logic signed [2*COORD_BITS+1:0]  d2_a_i,
  input  logic signed [2*COORD_BITS+1:0]  d2_b_i,
  output logic                            r_valid_o,
  input  logic                            r_ready_i,
  output pgarea_pkg::res_t                r_o
);
  import pgarea_pkg::*;

  localparam int unsigned PW = 2 * COORD_BITS + 2;
  localparam int unsigned TW = (2 * COORD_BITS + 1 > SUM_BITS) ? 2 * COORD_BITS + 1
                                                                : SUM_BITS;

  logic signed [PW:0]   dot0, dot1, dot2;
  logic signed [TW-1:0] c1, c2, tsum;
  logic                 right_d;

  logic                s2_valid_q, s2_valid_d, s2_go, s2_free, r_free;
  ctl_t                s2_ctl_q;
  logic [SUM_BITS-1:0] s2_term_q;
  logic                s2_right_q;

  logic [SUM_BITS-1:0] sum_q, sum_nxt;
  logic                right_q;
  logic                r_valid_q;
  res_t                r_q;

  assign dot0 = (PW+1)'(d0_a_i) + (PW+1)'(d0_b_i);
  assign dot1 = (PW+1)'(d1_a_i) + (PW+1)'(d1_b_i);
  assign dot2 = (PW+1)'(d2_a_i) + (PW+1)'(d2_b_i);

  assign c1   = TW'(cr_a_i) - TW'(cr_b_i);
  assign c2   = TW'(cl_a_i) - TW'(cl_b_i);
  assign tsum = (s1_ctl_i.do_cross ? c1 : '0) + (s1_ctl_i.ok ? c2 : '0);

  // Zero dot product, zero-length edges included, counts as a right angle
  assign right_d = (s1_ctl_i.do_dot0 && (dot0 == '0)) ||
                   (s1_ctl_i.ok && ((dot1 == '0) || (dot2 == '0)));

  // Non-final beats are absorbed here; a final one needs room in the result register
  assign r_free     = !r_valid_q || r_ready_i;
  assign s2_go      = s2_valid_q && (!s2_ctl_q.last || r_free);
  assign s2_free    = !s2_valid_q || s2_go;
  assign s1_ready_o = s2_free;

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s1_valid_i && s2_free) begin
      s2_valid_d = 1'b1;
    end else if (s2_go) begin
      s2_valid_d = 1'b0;
    end
  end

  assign sum_nxt = sum_q + s2_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      sum_q      <= '0;
      right_q    <= 1'b0;
      r_valid_q  <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (s2_go) begin
        if (s2_ctl_q.last) begin
          sum_q   <= '0;
          right_q <= 1'b0;
        end else begin
          sum_q   <= sum_nxt;
          right_q <= right_q | s2_right_q;
        end
      end
      if (s2_go && s2_ctl_q.last) begin
        r_valid_q <= 1'b1;
      end else if (r_ready_i) begin
        r_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s2_free) begin
      s2_ctl_q   <= s1_ctl_i;
      s2_term_q  <= tsum[SUM_BITS-1:0];
      s2_right_q <= right_d;
    end
    if (s2_go && s2_ctl_q.last) begin
      r_q.sum    <= s2_ctl_q.ok ? sum_nxt : '0;
      r_q.right  <= s2_ctl_q.ok && (right_q || s2_right_q);
      r_q.total  <= s2_ctl_q.total;
      r_q.status <= s2_ctl_q.status;
    end
  end

  assign r_valid_o = r_valid_q;
  assign r_o       = r_q;

endmodule

>>> rtl/pgarea_out.sv
// Output register: takes the magnitude of the shoelace sum and drives the result
// channel. Depends on pgarea_pkg and pgarea_res_if.
module pgarea_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             r_valid_i,
  output logic             r_ready_o,
  input  pgarea_pkg::res_t r_i,
  pgarea_res_if.source     res_o
);
  import pgarea_pkg::*;

  logic                  o_valid_q, load;
  logic [SUM_BITS-1:0]   mag;
  logic [AREA_BITS-1:0]  area_q;
  logic                  right_q;
  logic [TOTAL_BITS-1:0] total_q;
  status_e               status_q;

  assign r_ready_o = !o_valid_q || res_o.ready;
  assign load      = r_valid_i && r_ready_o;

  // Two's complement magnitude; the most negative sum wraps, top bit dropped
  assign mag = r_i.sum[SUM_BITS-1] ? (~r_i.sum + 1'b1) : r_i.sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (load) begin
      o_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      area_q   <= mag[AREA_BITS-1:0];
      right_q  <= r_i.right;
      total_q  <= r_i.total;
      status_q <= r_i.status;
    end
  end

  assign res_o.valid             = o_valid_q;
  assign res_o.twice_area        = area_q;
  assign res_o.right_angle_found = right_q;
  assign res_o.vertex_total      = total_q;
  assign res_o.status            = status_q;

endmodule

>>> rtl/polygon_area_right_angle_top.sv
// Streaming shoelace area and right-angle detector. Vertices of one closed polygon
// arrive one per beat, the final one flagged by last_vertex; a new vertex is taken
// every clock cycle while the result path gives no back-pressure. The block keeps
// the first two and the two latest vertices and forms all edge products in one
// registered multiplier bank; the result of a polygon then passes the terms, the
// accumulator and the magnitude registers behind the product register. The
// result holds twice the area exactly, whether any vertex has perpendicular or
// zero-length adjacent edges, the vertex count and a status: ok, too few vertices
// (under three) or too many (more than MAX_VERTICES; the extra vertices are ignored
// and the area reads zero).
// Depends on pgarea_pkg, the channel interfaces and the pgarea_* stage modules.
module polygon_area_right_angle_top #(
  parameter int unsigned MAX_VERTICES = pgarea_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pgarea_pkg::COORD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pgarea_vtx_if.sink   vtx_i,
  pgarea_res_if.source res_o
);
  import pgarea_pkg::*;

  localparam int unsigned CPW = 2 * COORD_BITS;
  localparam int unsigned PW  = 2 * COORD_BITS + 2;

  logic                  s1_valid, s1_ready;
  ctl_t                  s1_ctl;
  logic signed [CPW-1:0] cr_a, cr_b, cl_a, cl_b;
  logic signed [PW-1:0]  d0_a, d0_b, d1_a, d1_b, d2_a, d2_b;
  logic                  r_valid, r_ready;
  res_t                  r_data;

  pgarea_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vtx_i      (vtx_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_ctl_o   (s1_ctl),
    .cr_a_o     (cr_a),
    .cr_b_o     (cr_b),
    .cl_a_o     (cl_a),
    .cl_b_o     (cl_b),
    .d0_a_o     (d0_a),
    .d0_b_o     (d0_b),
    .d1_a_o     (d1_a),
    .d1_b_o     (d1_b),
    .d2_a_o     (d2_a),
    .d2_b_o     (d2_b)
  );

  pgarea_accum #(
    .COORD_BITS (COORD_BITS)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_ctl_i   (s1_ctl),
    .cr_a_i     (cr_a),
    .cr_b_i     (cr_b),
    .cl_a_i     (cl_a),
    .cl_b_i     (cl_b),
    .d0_a_i     (d0_a),
    .d0_b_i     (d0_b),
    .d1_a_i     (d1_a),
    .d1_b_i     (d1_b),
    .d2_a_i     (d2_a),
    .d2_b_i     (d2_b),
    .r_valid_o  (r_valid),
    .r_ready_i  (r_ready),
    .r_o        (r_data)
  );

  pgarea_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .r_valid_i (r_valid),
    .r_ready_o (r_ready),
    .r_i       (r_data),
    .res_o     (res_o)
  );

  // A rejected polygon carries neither area nor right-angle flag
  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid && (r_data.status != ST_OK) |-> (r_data.sum == '0) && !r_data.right)
    else $error("rejected polygon carries area or right-angle flag");

  // Overflow always reports the bound as the vertex count
  a_overflow_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid && (r_data.status == ST_TOO_MANY) |-> r_data.total == TOTAL_BITS'(MAX_VERTICES))
    else $error("overflowed polygon reports wrong vertex count");

  // Closing terms only on the final vertex of a polygon with enough vertices
  a_ok_only_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && s1_ctl.ok |-> s1_ctl.last && (s1_ctl.total >= TOTAL_BITS'(MIN_VERTICES)))
    else $error("closing terms flagged on a non-final or short polygon");

  // A result beat only ever follows a finished polygon in the result register
  a_out_from_r : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(r_valid))
    else $error("result beat without a finished polygon");

endmodule
